// ===== hw/rtl/lcs_length_table_top_macros.svh =====
// assertion macros for the lcs length table
`ifndef LCS_LENGTH_TABLE_TOP_MACROS_SVH
`define LCS_LENGTH_TABLE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define LCS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lcs check failed");
`define LCS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("lcs check failed");
`else
`define LCS_ASSERT(lbl, prop)
`define LCS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== hw/rtl/lcs_pkg.sv =====
package lcs_pkg;

  localparam int unsigned MAX_LEN = 128;
  localparam int unsigned LEN_W   = $clog2(MAX_LEN + 1);
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned VAL_W   = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_FIRST  = 2'd0,
    CMD_SECOND = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_e;

  // word moving down the cell chain: a table row or a finish token
  typedef struct packed {
    logic             valid;
    logic             fin;
    logic [SYM_W-1:0] sym;
    logic [VAL_W-1:0] left;
    logic [VAL_W-1:0] diag;
  } pass_t;

  function automatic logic [VAL_W-1:0] sat_inc(input logic [VAL_W-1:0] v);
    sat_inc = (&v) ? v : v + VAL_W'(1);
  endfunction

endpackage

// ===== hw/rtl/lcs_if.sv =====
interface lcs_in_if;
  logic                       valid;
  logic                       ready;
  logic [lcs_pkg::CMD_W-1:0]  command;
  logic [lcs_pkg::SYM_W-1:0]  symbol;

  modport source (output valid, output command, output symbol, input ready);
  modport sink   (input valid, input command, input symbol, output ready);
endinterface

interface lcs_out_if;
  logic                       valid;
  logic                       ready;
  logic [lcs_pkg::VAL_W-1:0]  lcs_length;
  logic                       overflow;

  modport source (output valid, output lcs_length, output overflow, input ready);
  modport sink   (input valid, input lcs_length, input overflow, output ready);
endinterface

// ===== hw/rtl/lcs_cell.sv =====
module lcs_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      load_i,
  input  logic [lcs_pkg::SYM_W-1:0] load_sym_i,
  input  logic                      prev_loaded_i,
  output logic                      loaded_o,
  input  lcs_pkg::pass_t            pass_i,
  output lcs_pkg::pass_t            pass_o
);

  logic                      loaded_q, loaded_d;
  logic [lcs_pkg::SYM_W-1:0] sym_q, sym_d;
  logic [lcs_pkg::VAL_W-1:0] val_q, val_d;
  lcs_pkg::pass_t            pass_q, pass_d;
  logic [lcs_pkg::VAL_W-1:0] cell_val;

  always_comb begin
    if (sym_q == pass_i.sym) begin
      cell_val = lcs_pkg::sat_inc(pass_i.diag);
    end else begin
      cell_val = (val_q > pass_i.left) ? val_q : pass_i.left;
    end
  end

  always_comb begin
    loaded_d = loaded_q;
    sym_d    = sym_q;
    val_d    = val_q;
    pass_d   = pass_i;
    if (load_i && !loaded_q && prev_loaded_i) begin
      loaded_d = 1'b1;
      sym_d    = load_sym_i;
    end
    if (pass_i.valid && loaded_q) begin
      if (pass_i.fin) begin
        pass_d.left = val_q;
        val_d       = '0;
        loaded_d    = 1'b0;
      end else begin
        pass_d.left = cell_val;
        pass_d.diag = val_q;
        val_d       = cell_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= 1'b0;
      sym_q    <= '0;
      val_q    <= '0;
      pass_q   <= '0;
    end else if (adv_i) begin
      loaded_q <= loaded_d;
      sym_q    <= sym_d;
      val_q    <= val_d;
      pass_q   <= pass_d;
    end
  end

  assign loaded_o = loaded_q;
  assign pass_o   = pass_q;

endmodule

// ===== hw/rtl/lcs_length_table_top.sv =====
// throughput: first and second string symbols one per cycle; after a finish the input
//   holds off until the finish token has run the MAX_LEN cell chain and the result is
//   registered
// reset: asynchronous active low; clears lengths, table cells, flags and output valid
`include "lcs_length_table_top_macros.svh"

module lcs_length_table_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  lcs_in_if.sink           in_i,
  lcs_out_if.source        out_o
);

  logic [lcs_pkg::LEN_W-1:0]  first_len_q, first_len_d;
  logic [lcs_pkg::LEN_W-1:0]  second_len_q, second_len_d;
  logic                       ovf_q, ovf_d;
  logic                       pend_ovf_q, pend_ovf_d;
  logic                       busy_q, busy_d;
  logic                       out_valid_q, out_valid_d;
  logic [lcs_pkg::VAL_W-1:0]  out_len_q;
  logic                       out_ovf_q;

  logic                       adv;
  logic                       acc;
  logic                       load;
  logic                       tail_fin;
  lcs_pkg::pass_t             head;
  lcs_pkg::pass_t             chain [lcs_pkg::MAX_LEN+1];
  logic [lcs_pkg::MAX_LEN:0]  loaded;

  assign tail_fin  = chain[lcs_pkg::MAX_LEN].valid && chain[lcs_pkg::MAX_LEN].fin;
  assign adv       = !(tail_fin && out_valid_q && !out_o.ready);
  assign in_i.ready = !busy_q && adv;
  assign acc       = in_i.valid && in_i.ready;

  always_comb begin
    first_len_d  = first_len_q;
    second_len_d = second_len_q;
    ovf_d        = ovf_q;
    pend_ovf_d   = pend_ovf_q;
    busy_d       = busy_q;
    load         = 1'b0;
    head         = '0;
    head.sym     = in_i.symbol;
    if (acc) begin
      unique case (lcs_pkg::cmd_e'(in_i.command))
        lcs_pkg::CMD_FIRST: begin
          if (second_len_q == '0) begin
            if (first_len_q < lcs_pkg::LEN_W'(lcs_pkg::MAX_LEN)) begin
              load        = 1'b1;
              first_len_d = first_len_q + lcs_pkg::LEN_W'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
        lcs_pkg::CMD_SECOND: begin
          if (second_len_q < lcs_pkg::LEN_W'(lcs_pkg::MAX_LEN)) begin
            head.valid   = 1'b1;
            second_len_d = second_len_q + lcs_pkg::LEN_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        lcs_pkg::CMD_FINISH: begin
          head.valid   = 1'b1;
          head.fin     = 1'b1;
          pend_ovf_d   = ovf_q;
          ovf_d        = 1'b0;
          first_len_d  = '0;
          second_len_d = '0;
          busy_d       = 1'b1;
        end
        default: begin
        end
      endcase
    end
    if (adv && tail_fin) begin
      busy_d = 1'b0;
    end
  end

  assign chain[0]  = head;
  assign loaded[0] = 1'b1;

  for (genvar k = 0; k < lcs_pkg::MAX_LEN; k++) begin : g_cell
    lcs_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .adv_i         (adv),
      .load_i        (load),
      .load_sym_i    (in_i.symbol),
      .prev_loaded_i (loaded[k]),
      .loaded_o      (loaded[k+1]),
      .pass_i        (chain[k]),
      .pass_o        (chain[k+1])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (adv && tail_fin) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_len_q  <= '0;
      second_len_q <= '0;
      ovf_q        <= 1'b0;
      pend_ovf_q   <= 1'b0;
      busy_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      first_len_q  <= first_len_d;
      second_len_q <= second_len_d;
      ovf_q        <= ovf_d;
      pend_ovf_q   <= pend_ovf_d;
      busy_q       <= busy_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && tail_fin) begin
      out_len_q <= chain[lcs_pkg::MAX_LEN].left;
      out_ovf_q <= pend_ovf_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.lcs_length = out_len_q;
  assign out_o.overflow   = out_ovf_q;

  `LCS_ASSERT(a_loaded_count, !busy_q |-> ($countones(loaded[lcs_pkg::MAX_LEN:1]) == first_len_q))
  `LCS_ASSERT(a_token_busy, tail_fin |-> busy_q)
  `LCS_ASSERT(a_finish_busy, (acc && in_i.command == lcs_pkg::CMD_FINISH) |=> busy_q)
  `LCS_ASSERT(a_result_src, $rose(out_valid_q) |-> $past(tail_fin))
  `LCS_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_o.valid)

endmodule
